@@ src/tcsb_pkg.sv @@
// shared types and constants for the text console scrollback unit
// no dependencies
`timescale 1ns / 1ps

package tcsb_pkg;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int GLYPH_W = 7;

    // command codes carried by the cmd field
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 3'd0,
        CMD_PAGE_UP   = 3'd1,
        CMD_PAGE_DOWN = 3'd2,
        CMD_HOME      = 3'd3,
        CMD_END       = 3'd4,
        CMD_READ      = 3'd5,
        CMD_EXPIRE    = 3'd6
    } cmd_t;

    // byte codes with special handling
    localparam logic [CHAR_W-1:0]  CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0]  CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
    localparam logic [GLYPH_W-1:0] CH_SPACE = 7'h20;
    localparam logic [GLYPH_W-1:0] CH_QMARK = 7'h3F;

    // per-transaction strobes from the console state logic
    typedef struct packed {
        logic char_we;
        logic len_we;
        logic rd_en;
        logic advanced;
    } tcsb_ctl_t;

endpackage

@@ src/tcsb_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tcsb_core.sv @@
// console state: write position, view offset, message count and their update
// uses tcsb_pkg
`timescale 1ns / 1ps

module tcsb_core
    import tcsb_pkg::*;
#(
    parameter int ROWS     = 80,
    parameter int COLS     = 56,
    parameter int VIS_ROWS = 10,
    parameter int MSG_ROWS = 4,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int VW = $clog2(VIS_ROWS),
    localparam int MW = $clog2(MSG_ROWS + 1),
    localparam int AW = $clog2(ROWS * COLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_go,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               show_msg,
    input  logic [VW-1:0]      vis_row,
    input  logic [CW-1:0]      read_col,
    input  logic               cfg_we,
    input  logic               cfg_show,
    output tcsb_ctl_t          ctl,
    output logic [AW-1:0]      char_waddr,
    output logic [GLYPH_W-1:0] char_wdata,
    output logic [AW-1:0]      char_raddr,
    output logic [RW-1:0]      len_waddr,
    output logic [CW-1:0]      len_wdata,
    output logic [RW-1:0]      len_raddr,
    output logic [RW-1:0]      row,
    output logic [CW-1:0]      col,
    output logic [RW-1:0]      offset,
    output logic [MW-1:0]      msg
);

    localparam int STEP = VIS_ROWS / 2;
    localparam int SMAX = ROWS - VIS_ROWS;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] off_reg, off_next;
    logic [MW-1:0] msg_reg, msg_next;
    logic          show_reg;

    logic [CW:0]   col_inc;
    logic [RW-1:0] row_inc;
    logic [RW:0]   off_up;
    logic [RW:0]   off_inc;
    logic [RW-1:0] off_mid;
    logic [MW-1:0] msg_mid;
    logic          adv;
    logic [RW:0]   back;
    logic [RW:0]   back_m;
    logic [RW:0]   rd_tmp;
    logic [RW-1:0] rd_row;

    always_comb
    begin
        col_inc = {1'b0, col_reg} + 1'b1;
        row_inc = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + 1'b1;
        off_up  = {1'b0, off_reg} + (RW + 1)'(STEP);

        // tab prints as space, high bytes as a question mark
        if (char_in == CH_TAB)
        begin
            char_wdata = CH_SPACE;
        end
        else if (char_in[CHAR_W-1])
        begin
            char_wdata = CH_QMARK;
        end
        else
        begin
            char_wdata = char_in[GLYPH_W-1:0];
        end

        row_next    = row_reg;
        col_next    = col_reg;
        off_mid     = off_reg;
        msg_mid     = msg_reg;
        ctl.char_we = 1'b0;
        ctl.len_we  = 1'b0;
        ctl.rd_en   = 1'b0;

        case (cmd)
            CMD_WRITE:
            begin
                if (char_in != CH_NUL && char_in != CH_CR)
                begin
                    ctl.len_we = 1'b1;
                    if (char_in == CH_LF)
                    begin
                        if (col_reg != '0)
                        begin
                            row_next = row_inc;
                            col_next = '0;
                        end
                    end
                    else
                    begin
                        ctl.char_we = 1'b1;
                        if (col_inc == (CW + 1)'(COLS))
                        begin
                            row_next = row_inc;
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_inc[CW-1:0];
                        end
                    end
                end
            end
            CMD_PAGE_UP:
            begin
                off_mid = (off_up > (RW + 1)'(SMAX)) ? RW'(SMAX) : off_up[RW-1:0];
            end
            CMD_PAGE_DOWN:
            begin
                off_mid = (off_reg > RW'(STEP)) ? off_reg - RW'(STEP) : '0;
            end
            CMD_HOME:
            begin
                off_mid = RW'(SMAX);
            end
            CMD_END:
            begin
                off_mid = '0;
            end
            CMD_READ:
            begin
                ctl.rd_en = ({1'b0, vis_row} < (VW + 1)'(VIS_ROWS));
            end
            CMD_EXPIRE:
            begin
                if (msg_reg != '0)
                begin
                    msg_mid = msg_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        adv          = (row_next != row_reg);
        ctl.advanced = adv;

        // a scrolled view follows the text it shows
        off_inc  = {1'b0, off_mid} + 1'b1;
        off_next = off_mid;
        if (adv && off_mid != '0)
        begin
            off_next = (off_inc > (RW + 1)'(SMAX)) ? RW'(SMAX) : off_inc[RW-1:0];
        end

        msg_next = msg_mid;
        if (adv && show_msg && msg_mid < MW'(MSG_ROWS))
        begin
            msg_next = msg_mid + 1'b1;
        end
        if (!show_reg)
        begin
            msg_next = '0;
        end

        // ring row shown at the requested visible line
        back   = (RW + 1)'(vis_row) + {1'b0, off_reg} + 1'b1;
        back_m = (back >= (RW + 1)'(ROWS)) ? back - (RW + 1)'(ROWS) : back;
        rd_tmp = {1'b0, row_reg} + (RW + 1)'(ROWS) - back_m;
        rd_row = (rd_tmp >= (RW + 1)'(ROWS)) ? RW'(rd_tmp - (RW + 1)'(ROWS))
                                             : rd_tmp[RW-1:0];
    end

    assign char_waddr = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    assign char_raddr = AW'(rd_row) * AW'(COLS) + AW'(read_col);
    assign len_waddr  = row_next;
    assign len_wdata  = col_next;
    assign len_raddr  = rd_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            off_reg  <= '0;
            msg_reg  <= '0;
            show_reg <= 1'b0;
        end
        else
        begin
            if (item_go)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                off_reg <= off_next;
                msg_reg <= msg_next;
            end
            if (cfg_we)
            begin
                show_reg <= cfg_show;
                if (!cfg_show)
                begin
                    msg_reg <= '0;
                end
            end
        end
    end

    assign row    = row_reg;
    assign col    = col_reg;
    assign offset = off_reg;
    assign msg    = msg_reg;

endmodule

@@ src/tcsb_skid.sv @@
// result register with one skid entry, decouples output stall from the pipe
// no dependencies
`timescale 1ns / 1ps

module tcsb_skid #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_vld,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         pop_vld,
    output logic [W-1:0] pop_data,
    input  logic         pop_stall
);

    logic         out_vld_reg;
    logic         full_reg;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] skid_data_reg;
    logic         held;

    assign held = out_vld_reg && pop_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else if (!full_reg)
        begin
            if (held)
            begin
                full_reg <= push_vld;
            end
            else
            begin
                out_vld_reg <= push_vld;
            end
        end
        else if (!pop_stall)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full_reg)
        begin
            if (held)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (!pop_stall)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign full     = full_reg;
    assign pop_vld  = out_vld_reg;
    assign pop_data = out_data_reg;

endmodule

@@ src/text_console_scrollback_unit.sv @@
// text console scrollback top level: input register, console state, stores, result skid
// uses tcsb_pkg, tcsb_core, tcsb_ram, tcsb_skid
// result path: input register, stage two, skid output register; state update and store
// access are single pass; throughput: one transaction per cycle while the skid is free
// reset: control state and row-length valid bits clear at once; no clearing pass,
//   the character store is left as it is and only written positions are ever returned
`timescale 1ns / 1ps

module text_console_scrollback_unit
    import tcsb_pkg::*;
#(
    parameter int ROWS     = 80,
    parameter int COLS     = 56,
    parameter int VIS_ROWS = 10,
    parameter int MSG_ROWS = 4,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int VW = $clog2(VIS_ROWS),
    localparam int MW = $clog2(MSG_ROWS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               show_msg,
    input  logic [VW-1:0]      vis_row,
    input  logic [CW-1:0]      read_col,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [GLYPH_W-1:0] read_char,
    output logic [RW-1:0]      cur_row,
    output logic [CW-1:0]      cur_col,
    output logic [RW-1:0]      scroll_offset,
    output logic [MW-1:0]      message_rows,
    output logic               row_advanced,
    // configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               show_messages
);

    localparam int AW   = $clog2(ROWS * COLS);
    localparam int PW   = GLYPH_W + RW + CW + RW + MW + 1;

    // pipe advances whenever the skid entry is free
    logic en;
    logic skid_full;
    logic item_go;

    // input register
    logic              s1_vld_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              smsg_reg;
    logic [VW-1:0]     vrow_reg;
    logic [CW-1:0]     rcol_reg;

    // second stage, waiting on the registered store reads
    logic          s2_vld_reg;
    logic          s2_rd_reg;
    logic          s2_adv_reg;
    logic [CW-1:0] s2_rcol_reg;
    logic          hit_vld_reg;

    // row-length valid bits stand in for the all-zero reset of that store
    logic [ROWS-1:0] len_vld_reg;

    tcsb_ctl_t          ctl;
    logic [AW-1:0]      char_waddr;
    logic [GLYPH_W-1:0] char_wdata;
    logic [AW-1:0]      char_raddr;
    logic [GLYPH_W-1:0] char_q;
    logic [RW-1:0]      len_waddr;
    logic [CW-1:0]      len_wdata;
    logic [RW-1:0]      len_raddr;
    logic [CW-1:0]      len_q;
    logic               char_we;
    logic               len_we;
    logic               rd_go;

    logic [RW-1:0]      st_row;
    logic [CW-1:0]      st_col;
    logic [RW-1:0]      st_off;
    logic [MW-1:0]      st_msg;
    logic [GLYPH_W-1:0] read_char_c;
    logic [PW-1:0]      res_data;
    logic [PW-1:0]      pop_data;

    assign en        = !skid_full;
    assign in_stall  = skid_full;
    assign cfg_ready = 1'b1;
    assign item_go   = en && s1_vld_reg;

    assign char_we = item_go && ctl.char_we;
    assign len_we  = item_go && ctl.len_we;
    assign rd_go   = item_go && ctl.rd_en;

    // input register: a transaction lands here on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            cmd_reg  <= cmd;
            char_reg <= char_in;
            smsg_reg <= show_msg;
            vrow_reg <= vis_row;
            rcol_reg <= read_col;
        end
    end

    // console state and next-state logic
    tcsb_core #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .VIS_ROWS (VIS_ROWS),
        .MSG_ROWS (MSG_ROWS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_go    (item_go),
        .cmd        (cmd_reg),
        .char_in    (char_reg),
        .show_msg   (smsg_reg),
        .vis_row    (vrow_reg),
        .read_col   (rcol_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_show   (show_messages),
        .ctl        (ctl),
        .char_waddr (char_waddr),
        .char_wdata (char_wdata),
        .char_raddr (char_raddr),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_raddr  (len_raddr),
        .row        (st_row),
        .col        (st_col),
        .offset     (st_off),
        .msg        (st_msg)
    );

    // character store, one entry per ring position
    tcsb_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (ROWS * COLS)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (char_wdata),
        .re    (rd_go),
        .raddr (char_raddr),
        .rdata (char_q)
    );

    // row length store
    tcsb_ram #(
        .WIDTH (CW),
        .DEPTH (ROWS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (rd_go),
        .raddr (len_raddr),
        .rdata (len_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
            s2_vld_reg  <= 1'b0;
        end
        else
        begin
            if (len_we)
            begin
                len_vld_reg[len_waddr] <= 1'b1;
            end
            if (en)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_rd_reg   <= ctl.rd_en;
            s2_adv_reg  <= ctl.advanced;
            s2_rcol_reg <= rcol_reg;
        end
        if (rd_go)
        begin
            hit_vld_reg <= len_vld_reg[len_raddr];
        end
    end

    // a never-written row has length zero, so nothing in it is readable
    assign read_char_c = (s2_rd_reg && hit_vld_reg && s2_rcol_reg < len_q) ? char_q : '0;

    // state registers already hold the values after the item in stage two
    assign res_data = {read_char_c, st_row, st_col, st_off, st_msg, s2_adv_reg};

    tcsb_skid #(
        .W (PW)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (s2_vld_reg),
        .push_data (res_data),
        .full      (skid_full),
        .pop_vld   (out_valid),
        .pop_data  (pop_data),
        .pop_stall (out_stall)
    );

    assign {read_char, cur_row, cur_col, scroll_offset, message_rows, row_advanced} = pop_data;

endmodule

@@ src/tcsb_checker.sv @@
// port-level checks for the text console scrollback unit, bound to the top level
// uses tcsb_pkg
`timescale 1ns / 1ps

module tcsb_checker
    import tcsb_pkg::*;
#(
    parameter int ROWS     = 80,
    parameter int COLS     = 56,
    parameter int VIS_ROWS = 10,
    parameter int MSG_ROWS = 4,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int MW = $clog2(MSG_ROWS + 1)
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [GLYPH_W-1:0] read_char,
    input logic [RW-1:0]      cur_row,
    input logic [CW-1:0]      cur_col,
    input logic [RW-1:0]      scroll_offset,
    input logic [MW-1:0]      message_rows,
    input logic               row_advanced
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_char) && $stable(cur_row)
            && $stable(cur_col) && $stable(scroll_offset) && $stable(message_rows)
            && $stable(row_advanced))
        else $error("result changed while stalled");

    // state fields stay inside their ranges
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cur_col) < COLS) && (int'(cur_row) < ROWS)
            && (int'(scroll_offset) <= ROWS - VIS_ROWS) && (int'(message_rows) <= MSG_ROWS))
        else $error("result field out of range");

    // a row advance always leaves the write column at the start
    a_adv_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_advanced |-> cur_col == '0)
        else $error("row advanced with nonzero column");

    // input back-pressure only follows a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output stall");

endmodule

bind text_console_scrollback_unit tcsb_checker #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .VIS_ROWS (VIS_ROWS),
    .MSG_ROWS (MSG_ROWS)
) u_tcsb_checker (.*);

@@ tb/sv/tcsb_checker.sv @@
// scoreboard for the text console scrollback unit: predicts every result and compares
// depends on tcsb_pkg for command and byte codes
`timescale 1ns / 1ps

module tcsb_scoreboard
    import tcsb_pkg::*;
#(
    parameter int ROWS     = 80,
    parameter int COLS     = 56,
    parameter int VIS_ROWS = 10,
    parameter int MSG_ROWS = 4,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int VW = $clog2(VIS_ROWS),
    localparam int MW = $clog2(MSG_ROWS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               show_msg,
    input  logic [VW-1:0]      vis_row,
    input  logic [CW-1:0]      read_col,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [GLYPH_W-1:0] read_char,
    input  logic [RW-1:0]      cur_row,
    input  logic [CW-1:0]      cur_col,
    input  logic [RW-1:0]      scroll_offset,
    input  logic [MW-1:0]      message_rows,
    input  logic               row_advanced,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               show_messages,
    output int                 failures,
    output int                 pending
);

    localparam int SCROLL_STEP = VIS_ROWS / 2;
    localparam int SCROLL_MAX  = ROWS - VIS_ROWS;
    localparam logic [CHAR_W-1:0] FIRST_HIGH_BYTE = 8'h80;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [RW-1:0]      row;
        logic [CW-1:0]      col;
        logic [RW-1:0]      offset;
        logic [MW-1:0]      msgs;
        logic               adv;
    } console_view_t;

    // mirrored console state
    logic [GLYPH_W-1:0] glyph_mem [ROWS*COLS];
    logic [CW-1:0]      line_len [ROWS];
    int unsigned        wr_row;
    int unsigned        wr_col;
    int unsigned        view_off;
    int unsigned        msg_cnt;
    logic               show_en;

    console_view_t view_q[$];
    console_view_t want;
    int            fail_count = 0;
    int            result_idx = 0;

    assign failures = fail_count;
    assign pending  = view_q.size();

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (fail_count < MAX_REPORTS)
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $realtime, result_idx, what, got, exp_val);
        fail_count++;
    endtask

    task automatic check_field(input string what, input int got, input int exp_val);
        if (got != exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    function automatic void next_line();
        wr_col = 0;
        wr_row = (wr_row + 1) % ROWS;
    endfunction

    // apply one command to the mirror and return what the block should report
    function automatic console_view_t step_console(
        input logic [CMD_W-1:0]  op,
        input logic [CHAR_W-1:0] data,
        input logic              smsg,
        input logic [VW-1:0]     vrow,
        input logic [CW-1:0]     rcol
    );
        console_view_t     res;
        int unsigned       start_row;
        int unsigned       back;
        int unsigned       src_row;
        logic [CHAR_W-1:0] glyph;
        res = '0;
        start_row = wr_row;
        glyph = data;
        case (op)
            CMD_WRITE:
            begin
                if (data != CH_NUL && data != CH_CR)
                begin
                    if (data == CH_LF)
                    begin
                        if (wr_col != 0)
                            next_line();
                    end
                    else
                    begin
                        if (data == CH_TAB)
                            glyph = {1'b0, CH_SPACE};
                        if (data >= FIRST_HIGH_BYTE)
                            glyph = {1'b0, CH_QMARK};
                        if (wr_col < COLS)
                            glyph_mem[wr_row * COLS + wr_col] = glyph[GLYPH_W-1:0];
                        wr_col++;
                        if (wr_col >= COLS)
                            next_line();
                    end
                    // length lands on the new row after a wrap or newline
                    line_len[wr_row] = CW'(wr_col);
                end
            end
            CMD_PAGE_UP:
            begin
                view_off += SCROLL_STEP;
                if (view_off > SCROLL_MAX)
                    view_off = SCROLL_MAX;
            end
            CMD_PAGE_DOWN:
                view_off = (view_off > SCROLL_STEP) ? view_off - SCROLL_STEP : 0;
            CMD_HOME:
                view_off = SCROLL_MAX;
            CMD_END:
                view_off = 0;
            CMD_READ:
            begin
                if (vrow < VIS_ROWS)
                begin
                    back = (vrow + 1 + view_off) % ROWS;
                    src_row = (wr_row + ROWS - back) % ROWS;
                    if (rcol < line_len[src_row] && rcol < COLS)
                        res.glyph = glyph_mem[src_row * COLS + rcol];
                end
            end
            CMD_EXPIRE:
            begin
                if (msg_cnt > 0)
                    msg_cnt--;
            end
            default:
                ;
        endcase

        if (wr_row != start_row)
        begin
            res.adv = 1'b1;
            if (view_off > 0)
            begin
                view_off++;
                if (view_off > SCROLL_MAX)
                    view_off = SCROLL_MAX;
            end
            if (smsg && msg_cnt < MSG_ROWS)
                msg_cnt++;
        end
        if (!show_en)
            msg_cnt = 0;

        res.row    = RW'(wr_row);
        res.col    = CW'(wr_col);
        res.offset = RW'(view_off);
        res.msgs   = MW'(msg_cnt);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (glyph_mem[i])
                glyph_mem[i] = '0;
            foreach (line_len[i])
                line_len[i] = '0;
            wr_row   = 0;
            wr_col   = 0;
            view_off = 0;
            msg_cnt  = 0;
            show_en  = 1'b0;
            view_q.delete();
        end
        else
        begin
            // results first so a transaction taken at this edge never matches itself
            if (out_valid && !out_stall)
            begin
                if (view_q.size() == 0)
                    report_mismatch("arrived with nothing outstanding", 1, 0);
                else
                begin
                    want = view_q.pop_front();
                    check_field("read_char", int'(read_char), int'(want.glyph));
                    check_field("cur_row", int'(cur_row), int'(want.row));
                    check_field("cur_col", int'(cur_col), int'(want.col));
                    check_field("scroll_offset", int'(scroll_offset), int'(want.offset));
                    check_field("message_rows", int'(message_rows), int'(want.msgs));
                    check_field("row_advanced", int'(row_advanced), int'(want.adv));
                end
                result_idx++;
            end
            if (cfg_valid && cfg_ready)
            begin
                show_en = show_messages;
                if (!show_en)
                    msg_cnt = 0;
            end
            if (in_valid && !in_stall)
                view_q.push_back(step_console(cmd, char_in, show_msg, vis_row, read_col));
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the text console scrollback testbench: clock, reset, stimulus and verdict
// depends on tcsb_pkg, text_console_scrollback_unit and tcsb_scoreboard
`timescale 1ns / 1ps

module tb_top;
    import tcsb_pkg::*;

    localparam int ROWS     = 80;
    localparam int COLS     = 56;
    localparam int VIS_ROWS = 10;
    localparam int MSG_ROWS = 4;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int VW = $clog2(VIS_ROWS);
    localparam int MW = $clog2(MSG_ROWS + 1);

    localparam int CLK_PERIOD = 10;
    localparam int LIMIT_NS   = 10_000_000;
    localparam int LONG_HOLD  = 60;           // receiver hold-off that backs up the block
    localparam int DRAIN_MAX  = 5000;

    // command 7 has no meaning in the block; it must leave the state alone
    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_in;
    logic               show_msg;
    logic [VW-1:0]      vis_row;
    logic [CW-1:0]      read_col;
    logic               out_valid;
    logic               out_stall;
    logic [GLYPH_W-1:0] read_char;
    logic [RW-1:0]      cur_row;
    logic [CW-1:0]      cur_col;
    logic [RW-1:0]      scroll_offset;
    logic [MW-1:0]      message_rows;
    logic               row_advanced;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               show_messages;

    int failures;
    int pending;
    int hold_ask = 0;    // bumped by the stimulus to request one long receiver hold-off
    int calm_left = 0;   // transactions still to send back to back with no gaps
    int line_left = 5;   // printable characters before the next newline

    text_console_scrollback_unit #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .VIS_ROWS (VIS_ROWS),
        .MSG_ROWS (MSG_ROWS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .char_in       (char_in),
        .show_msg      (show_msg),
        .vis_row       (vis_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_char     (read_char),
        .cur_row       (cur_row),
        .cur_col       (cur_col),
        .scroll_offset (scroll_offset),
        .message_rows  (message_rows),
        .row_advanced  (row_advanced),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .show_messages (show_messages)
    );

    // the checker sees the same pins as the block and does all the predicting
    tcsb_scoreboard #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .VIS_ROWS (VIS_ROWS),
        .MSG_ROWS (MSG_ROWS)
    ) scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .char_in       (char_in),
        .show_msg      (show_msg),
        .vis_row       (vis_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_char     (read_char),
        .cur_row       (cur_row),
        .cur_col       (cur_col),
        .scroll_offset (scroll_offset),
        .message_rows  (message_rows),
        .row_advanced  (row_advanced),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .show_messages (show_messages),
        .failures      (failures),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case a handshake hangs
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall pattern, plus one long hold-off per request
    initial
    begin : result_side
        int hold_done;
        int pick;
        int span;
        logic level;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            if (hold_ask != hold_done)
            begin
                // long hold-off while the sender keeps going, so the block backs up
                hold_done = hold_ask;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                level = 1'b1;
                if (pick < 45)
                begin
                    // open stretch, no stalls at all
                    level = 1'b0;
                    span = $urandom_range(1, 40);
                end
                else if (pick < 90)
                    span = $urandom_range(1, 3);
                else if (pick < 97)
                    span = $urandom_range(4, 12);
                else
                    span = $urandom_range(15, 40);
                repeat (span)
                begin
                    @(negedge clk);
                    out_stall <= level;
                end
            end
        end
    end

    // offer one transaction after a random gap and hold it until taken
    task automatic send_item(
        input logic [CMD_W-1:0]  op,
        input logic [CHAR_W-1:0] data,
        input logic              smsg,
        input logic [VW-1:0]     vrow,
        input logic [CW-1:0]     rcol
    );
        int pick;
        int gap;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                calm_left = $urandom_range(20, 60);
            else if (pick < 70)
                gap = 0;
            else if (pick < 95)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 30);
        end
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= op;
        char_in  <= data;
        show_msg <= smsg;
        vis_row  <= vrow;
        read_col <= rcol;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // register writes only go out once every result has come back
    task automatic set_show_messages(input logic value);
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        show_messages <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly lines of printable text of random length with newlines, mixed with
    // reads, scrolling and expiry; a few odd bytes and the spare command as noise
    task automatic run_random(input int count);
        int pick;
        logic [CMD_W-1:0]  op;
        logic [CHAR_W-1:0] data;
        logic              smsg;
        logic [VW-1:0]     vrow;
        logic [CW-1:0]     rcol;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            op   = CMD_WRITE;
            data = CHAR_W'($urandom_range(0, 255));
            smsg = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0)
                vrow = VW'($urandom_range(VIS_ROWS, (1 << VW) - 1));
            else
                vrow = VW'($urandom_range(0, VIS_ROWS - 1));
            if ($urandom_range(0, 1) == 0)
                rcol = CW'($urandom_range(0, 15));
            else
                rcol = CW'($urandom_range(0, (1 << CW) - 1));
            if (pick < 60)
            begin
                if (line_left == 0)
                begin
                    data = CH_LF;
                    // now and then a long line, mostly long enough to wrap the row
                    if ($urandom_range(0, 9) == 0)
                        line_left = $urandom_range(50, 130);
                    else
                        line_left = $urandom_range(1, 20);
                end
                else
                begin
                    data = CHAR_W'($urandom_range(8'h20, 8'h7e));
                    line_left--;
                end
            end
            else if (pick < 80)
                op = CMD_READ;
            else if (pick < 90)
                op = CMD_W'($urandom_range(CMD_PAGE_UP, CMD_END));
            else if (pick < 96)
                op = CMD_EXPIRE;
            else if (pick < 99)
                op = CMD_WRITE;   // any byte at all, control and high bytes included
            else
                op = CMD_SPARE;
            send_item(op, data, smsg, vrow, rcol);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int drain_cycles;

        // every input known from time zero
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = CMD_WRITE;
        char_in       = '0;
        show_msg      = 1'b0;
        vis_row       = '0;
        read_col      = '0;
        cfg_valid     = 1'b0;
        show_messages = 1'b0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        set_show_messages(1'b1);

        // directed: byte translation and the ignored bytes
        send_item(CMD_WRITE, 8'h41, 1'b0, '0, '0);
        send_item(CMD_WRITE, CH_NUL, 1'b1, '0, '0);   // zero byte changes nothing
        send_item(CMD_WRITE, CH_CR, 1'b1, '0, '0);    // carriage return ignored
        send_item(CMD_WRITE, CH_TAB, 1'b0, '0, '0);   // prints as a space
        send_item(CMD_WRITE, 8'hff, 1'b0, '0, '0);    // high bytes print as a question mark
        send_item(CMD_WRITE, 8'h80, 1'b0, '0, '0);
        send_item(CMD_WRITE, 8'h7f, 1'b0, '0, '0);
        send_item(CMD_WRITE, 8'h01, 1'b0, '0, '0);    // other control bytes stored raw
        send_item(CMD_WRITE, CH_LF, 1'b1, '0, '0);    // ends the row, counts a message
        send_item(CMD_WRITE, CH_LF, 1'b1, '0, '0);    // newline at column zero does nothing
        // reads: inside the row, past its end, unwritten row, out-of-range row and column
        send_item(CMD_READ, 8'hff, 1'b1, 4'd0, 6'd0);
        send_item(CMD_READ, 8'h00, 1'b0, 4'd0, 6'd5);
        send_item(CMD_READ, 8'h00, 1'b0, 4'd0, 6'd6);
        send_item(CMD_READ, 8'h00, 1'b0, 4'd15, 6'd63);
        send_item(CMD_READ, 8'h00, 1'b0, 4'd9, 6'd0);
        // scrolling to both bounds, and a row advance while scrolled back
        send_item(CMD_PAGE_UP, 8'h00, 1'b0, '0, '0);
        send_item(CMD_HOME, 8'h00, 1'b0, '0, '0);
        send_item(CMD_PAGE_DOWN, 8'h00, 1'b0, '0, '0);
        send_item(CMD_WRITE, 8'h42, 1'b0, '0, '0);
        send_item(CMD_WRITE, CH_LF, 1'b1, '0, '0);
        send_item(CMD_END, 8'h00, 1'b0, '0, '0);
        send_item(CMD_PAGE_DOWN, 8'h00, 1'b0, '0, '0);  // already at the live tail
        // message expiry down past zero, then the spare command
        send_item(CMD_EXPIRE, 8'h00, 1'b0, '0, '0);
        send_item(CMD_EXPIRE, 8'h00, 1'b0, '0, '0);
        send_item(CMD_EXPIRE, 8'h00, 1'b0, '0, '0);
        send_item(CMD_SPARE, 8'hff, 1'b1, 4'd15, 6'd63);
        @(negedge clk);
        in_valid <= 1'b0;

        // random traffic with messages shown, then hidden, then shown again
        run_random(650);
        set_show_messages(1'b0);
        run_random(400);
        set_show_messages(1'b1);
        hold_ask++;
        run_random(350);
        hold_ask++;
        run_random(350);

        // drain what is still in flight, bounded
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_MAX)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        // then keep the clock running so a stray extra result would still be caught
        repeat (4) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/tcsb_pkg.sv
src/tcsb_ram.sv
src/tcsb_core.sv
src/tcsb_skid.sv
src/text_console_scrollback_unit.sv
src/tcsb_checker.sv
tb/sv/tcsb_checker.sv
tb/sv/tb_top.sv
